// ----- hdl/dmxtx_pkg.sv -----
// shared types, codes and helpers for the dmx512 frame transmitter
`default_nettype none

package dmxtx_pkg;

	// payload widths
	localparam int OP_W       = 2;
	localparam int CHANNEL_W  = 10;
	localparam int LEVEL_W    = 8;
	localparam int PHASE_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int TICKS_W    = 16;
	localparam int SLOT_W     = 11;
	localparam int BIT_IDX_W  = 4;

	// last bit time of a slot (start, eight data, two stop)
	localparam logic [BIT_IDX_W-1:0] SLOT_LAST_BIT = BIT_IDX_W'(10);

	// item operations
	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BREAK       = 2'd0,
		CFG_MARK_AFTER  = 2'd1,
		CFG_MARK_BEFORE = 2'd2,
		CFG_START_CODE  = 2'd3
	} cfg_idx_t;

	// register reset values
	localparam logic [TICKS_W-1:0] BREAK_RST       = TICKS_W'(23);
	localparam logic [TICKS_W-1:0] MARK_AFTER_RST  = TICKS_W'(3);
	localparam logic [TICKS_W-1:0] MARK_BEFORE_RST = TICKS_W'(1);
	localparam logic [LEVEL_W-1:0] START_CODE_RST  = LEVEL_W'(0);

	// line sequencer states
	typedef enum logic [3:0] {
		ST_MBB   = 4'b0001,
		ST_BREAK = 4'b0010,
		ST_MAB   = 4'b0100,
		ST_FRAME = 4'b1000
	} line_state_t;

	// phase codes as seen on the result channel
	localparam logic [PHASE_W-1:0] PHASE_MBB   = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_BREAK = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_MAB   = 2'd2;
	localparam logic [PHASE_W-1:0] PHASE_FRAME = 2'd3;

	function automatic logic [PHASE_W-1:0] phase_code(input line_state_t st);
		logic [PHASE_W-1:0] code;
		unique case (st)
			ST_MBB:   code = PHASE_MBB;
			ST_BREAK: code = PHASE_BREAK;
			ST_MAB:   code = PHASE_MAB;
			ST_FRAME: code = PHASE_FRAME;
			default:  code = PHASE_MBB;
		endcase
		return code;
	endfunction

	// start bit low, data lsb first, two stop bits high
	function automatic logic [SLOT_W-1:0] frame_slot(input logic [LEVEL_W-1:0] data);
		return {2'b11, data, 1'b0};
	endfunction

	// zero length counts as one tick
	function automatic logic [TICKS_W-1:0] at_least_one(input logic [TICKS_W-1:0] v);
		return (v == '0) ? TICKS_W'(1) : v;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/dmxtx_item_if.sv -----
// input item channel: tick, channel write or channel read
`default_nettype none

interface dmxtx_item_if;
	logic                                valid;
	logic                                ready;
	logic [dmxtx_pkg::OP_W-1:0]          op;
	logic [dmxtx_pkg::CHANNEL_W-1:0]     channel;
	logic [dmxtx_pkg::LEVEL_W-1:0]       level;

	modport source (output valid, output op, output channel, output level, input ready);
	modport sink   (input valid, input op, input channel, input level, output ready);
endinterface

`default_nettype wire

// ----- hdl/dmxtx_result_if.sv -----
// result channel: line level, phase, accept flag and read data
`default_nettype none

interface dmxtx_result_if;
	logic                              valid;
	logic                              ready;
	logic                              tx_line;
	logic [dmxtx_pkg::PHASE_W-1:0]     phase;
	logic                              accepted;
	logic [dmxtx_pkg::LEVEL_W-1:0]     read_level;

	modport source (output valid, output tx_line, output phase, output accepted,
		output read_level, input ready);
	modport sink   (input valid, input tx_line, input phase, input accepted,
		input read_level, output ready);
endinterface

`default_nettype wire

// ----- hdl/dmxtx_cfg_if.sv -----
// configuration write channel
`default_nettype none

interface dmxtx_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [dmxtx_pkg::CFG_IDX_W-1:0]     index;
	logic [dmxtx_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/dmxtx_ram.sv -----
// generic simple dual port ram, one write port, one registered read port
`default_nettype none

module dmxtx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/dmx512_frame_transmitter.sv -----
// dmx512 frame transmitter top level: channel store, line sequencer, result pipeline
//
//  channel  | dir | transfer moves                       | handshake
//  ---------+-----+--------------------------------------+-----------
//  item     | in  | op, channel, level                   | valid/ready
//  result   | out | tx_line, phase, accepted, read_level | valid/ready
//  cfg      | in  | index, data                          | valid/ready
//
// one item per cycle while item.ready holds; results pass ram read, then output reg
// after reset the store is cleared, one entry a cycle: item.ready stays low until
//   the last entry is cleared, cfg writes are taken throughout
// a result stall backs up through the pipeline; outside the clearing pass item.ready
//   drops only when both the read stage and the output register are full
// a slot load at a slot boundary reads the ram; its data feeds the shifter next cycle
`default_nettype none

module dmx512_frame_transmitter #(
	parameter int CHANNEL_COUNT = 512
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	dmxtx_item_if.sink    item,
	dmxtx_result_if.source result,
	dmxtx_cfg_if.sink     cfg
);

	localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int SW = $clog2(CHANNEL_COUNT + 1);
	localparam logic [dmxtx_pkg::CHANNEL_W:0] CH_LIMIT =
		(dmxtx_pkg::CHANNEL_W + 1)'(CHANNEL_COUNT);
	localparam logic [SW-1:0] LAST_SLOT = SW'(CHANNEL_COUNT);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CHANNEL_COUNT - 1);

	// configuration registers
	logic [dmxtx_pkg::TICKS_W-1:0] break_q;
	logic [dmxtx_pkg::TICKS_W-1:0] mark_after_q;
	logic [dmxtx_pkg::TICKS_W-1:0] mark_before_q;
	logic [dmxtx_pkg::LEVEL_W-1:0] start_code_q;

	// line sequencer state
	dmxtx_pkg::line_state_t        state_q, state_d;
	logic [dmxtx_pkg::TICKS_W-1:0] count_q, count_d;
	logic [SW-1:0]                 slot_q, slot_d;
	logic [dmxtx_pkg::BIT_IDX_W-1:0] bit_q, bit_d;
	logic [dmxtx_pkg::SLOT_W-1:0]  shift_q, shift_d, shift_eff;
	logic                          load_pend_q;
	logic                          load_req;

	// store clearing after reset
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// pipeline
	logic                           s1_valid_q;
	logic                           tx_s1, acc_s1, rd_s1;
	logic [dmxtx_pkg::PHASE_W-1:0]  phase_s1;
	logic                           out_valid_q;
	logic                           tx_q, acc_q;
	logic [dmxtx_pkg::PHASE_W-1:0]  phase_q;
	logic [dmxtx_pkg::LEVEL_W-1:0]  read_level_q;

	logic                           s1_adv, in_ready, take;
	logic                           in_range, is_tick, is_write, is_read;
	logic                           tx_d;

	// ram ports
	logic                           ram_we, ram_re;
	logic [AW-1:0]                  ram_waddr, ram_raddr;
	logic [dmxtx_pkg::LEVEL_W-1:0]  ram_wdata, ram_rdata;

	// handshakes
	assign s1_adv   = s1_valid_q && (!out_valid_q || result.ready);
	assign in_ready = !clr_busy_q && (!s1_valid_q || s1_adv);
	assign take     = item.valid && in_ready;
	assign item.ready = in_ready;
	assign cfg.ready  = 1'b1;

	assign in_range = {1'b0, item.channel} < CH_LIMIT;
	assign is_tick  = take && (item.op == dmxtx_pkg::OP_TICK);
	assign is_write = take && (item.op == dmxtx_pkg::OP_WRITE) && in_range;
	assign is_read  = take && (item.op == dmxtx_pkg::OP_READ) && in_range;

	// slot just loaded from the store takes over the shifter
	assign shift_eff = load_pend_q ? dmxtx_pkg::frame_slot(ram_rdata) : shift_q;

	// line sequencer next state for a tick
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		slot_d   = slot_q;
		bit_d    = bit_q;
		shift_d  = shift_eff;
		load_req = 1'b0;
		if (is_tick) begin
			unique case (state_q)
				dmxtx_pkg::ST_FRAME: begin
					if (bit_q == dmxtx_pkg::SLOT_LAST_BIT) begin
						bit_d = '0;
						if (slot_q == LAST_SLOT) begin
							// frame done, idle mark before the next break
							state_d = dmxtx_pkg::ST_MBB;
							count_d = dmxtx_pkg::at_least_one(mark_before_q);
							slot_d  = '0;
							shift_d = '1;
						end else begin
							// next slot carries channel slot_q, fetched from the store
							slot_d   = slot_q + SW'(1);
							load_req = 1'b1;
						end
					end else begin
						shift_d = shift_eff >> 1;
						bit_d   = bit_q + dmxtx_pkg::BIT_IDX_W'(1);
					end
				end
				dmxtx_pkg::ST_MBB: begin
					if (count_q > dmxtx_pkg::TICKS_W'(1)) begin
						count_d = count_q - dmxtx_pkg::TICKS_W'(1);
					end else begin
						state_d = dmxtx_pkg::ST_BREAK;
						count_d = dmxtx_pkg::at_least_one(break_q);
						shift_d = '1;
					end
				end
				dmxtx_pkg::ST_BREAK: begin
					if (count_q > dmxtx_pkg::TICKS_W'(1)) begin
						count_d = count_q - dmxtx_pkg::TICKS_W'(1);
					end else begin
						state_d = dmxtx_pkg::ST_MAB;
						count_d = dmxtx_pkg::at_least_one(mark_after_q);
						shift_d = '1;
					end
				end
				dmxtx_pkg::ST_MAB: begin
					if (count_q > dmxtx_pkg::TICKS_W'(1)) begin
						count_d = count_q - dmxtx_pkg::TICKS_W'(1);
					end else begin
						// frame opens with the start code slot
						state_d = dmxtx_pkg::ST_FRAME;
						count_d = '0;
						slot_d  = '0;
						bit_d   = '0;
						shift_d = dmxtx_pkg::frame_slot(start_code_q);
					end
				end
				default: begin
					state_d = state_q;
				end
			endcase
		end
	end

	// line level after the item; a freshly loaded slot starts with its start bit
	always_comb begin
		unique case (state_d)
			dmxtx_pkg::ST_BREAK: tx_d = 1'b0;
			dmxtx_pkg::ST_FRAME: tx_d = load_req ? 1'b0 : shift_d[0];
			default:             tx_d = 1'b1;
		endcase
	end

	// channel store port usage: clearing pass, writes, reads and slot loads
	assign ram_we    = clr_busy_q || is_write;
	assign ram_waddr = clr_busy_q ? clr_addr_q : item.channel[AW-1:0];
	assign ram_wdata = clr_busy_q ? '0 : item.level;
	assign ram_re    = load_req || is_read;
	assign ram_raddr = load_req ? slot_q[AW-1:0] : item.channel[AW-1:0];

	dmxtx_ram #(
		.WIDTH (dmxtx_pkg::LEVEL_W),
		.DEPTH (CHANNEL_COUNT)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_q       <= dmxtx_pkg::BREAK_RST;
			mark_after_q  <= dmxtx_pkg::MARK_AFTER_RST;
			mark_before_q <= dmxtx_pkg::MARK_BEFORE_RST;
			start_code_q  <= dmxtx_pkg::START_CODE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				dmxtx_pkg::CFG_BREAK:       break_q       <= cfg.data;
				dmxtx_pkg::CFG_MARK_AFTER:  mark_after_q  <= cfg.data;
				dmxtx_pkg::CFG_MARK_BEFORE: mark_before_q <= cfg.data;
				dmxtx_pkg::CFG_START_CODE:  start_code_q  <= cfg.data[dmxtx_pkg::LEVEL_W-1:0];
				default:                    start_code_q  <= start_code_q;
			endcase
		end
	end

	// sequencer and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dmxtx_pkg::ST_BREAK;
			count_q     <= dmxtx_pkg::BREAK_RST;
			slot_q      <= '0;
			bit_q       <= '0;
			shift_q     <= '1;
			load_pend_q <= 1'b0;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			slot_q      <= slot_d;
			bit_q       <= bit_d;
			shift_q     <= shift_d;
			load_pend_q <= load_req;
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == LAST_ADDR) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			s1_valid_q  <= take || (s1_valid_q && !s1_adv);
			out_valid_q <= s1_adv || (out_valid_q && !result.ready);
		end
	end

	// read stage payload, store data arrives alongside
	always_ff @(posedge clk) begin
		if (take) begin
			tx_s1    <= tx_d;
			phase_s1 <= dmxtx_pkg::phase_code(state_d);
			acc_s1   <= is_write || is_read;
			rd_s1    <= is_read;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			tx_q         <= tx_s1;
			phase_q      <= phase_s1;
			acc_q        <= acc_s1;
			read_level_q <= rd_s1 ? ram_rdata : '0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.tx_line    = tx_q;
	assign result.phase      = phase_q;
	assign result.accepted   = acc_q;
	assign result.read_level = read_level_q;

endmodule

`default_nettype wire
